FILE: rtl/core/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg: shared types and constants of the 4x4 window median filter
// Field widths, register map and the control bundle carried down the pipeline.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int VALUE_W   = 32;   // output value field
  localparam int IDX_W     = 10;   // out_row / out_col fields
  localparam int REG_W     = 11;   // num_rows / num_cols registers
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int WIN_SIZE  = 16;   // 4x4 window
  localparam int MED_RANK  = 8;    // upper median of 16
  localparam int NUM_RES   = 4;    // results one word can cause
  localparam int OUT_TDATA_W = ((VALUE_W + 2 * IDX_W + 7) / 8) * 8;

  // Register indexes (paddr[2])
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // Result slots of one input word, in emission order
  localparam logic [1:0] RES_DIAG     = 2'd0;  // cell (r-1, c-1)
  localparam logic [1:0] RES_ROW_END  = 2'd1;  // cell (r-1, c)
  localparam logic [1:0] RES_LAST_ROW = 2'd2;  // cell (r, c-1)
  localparam logic [1:0] RES_CORNER   = 2'd3;  // cell (r, c)

  // Line buffer slot of the current row (row mod 3)
  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;

  typedef struct packed {
    logic [NUM_RES-1:0] emit;      // which result slots this word produces
    logic               interior;  // diagonal cell is an interior cell
    logic [IDX_W-1:0]   row;       // row of the input word, low bits
    logic [IDX_W-1:0]   col;       // column of the input word, low bits
  } ctl_t;

endpackage

FILE: rtl/core/window_median_filter_4x4_core.sv
// ----------------------------------------------------------------------------
// window_median_filter_4x4_core: streaming 4x4 upper-median filter
// Raster-order grid samples in, median or passed-through cells out.
// ----------------------------------------------------------------------------
// Samples enter in raster order, one word per cycle while s_tready is high,
// and each layer of num_rows x num_cols cells is followed directly by the
// next. Interior cells (2 <= row <= rows-3, 2 <= col <= cols-3) get the upper
// median (rank 8 of 16) of the 4x4 window on rows row-2..row+1 and columns
// col-2..col+1; all other cells pass through with is_median low. The word at
// (r,c) completes cell (r-1,c-1), and at a row end or in the last row it also
// flushes the border cells it completes, so one word yields 0 to 4 result
// words; m_tlast marks the last of them. Throughput is one input word per
// cycle, limited by the output port, which moves one result word per cycle
// while m_tready is high: a word causing k > 1 results holds s_tready low
// until its last result is taken. A word passes the line buffer read, compare
// matrix and rank select registers before its first result. Three line buffers
// of MAX_COLS samples each hold the previous rows; they need no clearing pass,
// so the block is ready right after reset. Writing num_rows or num_cols
// restarts the layer at cell (0,0); write them only while the block is idle.
// ----------------------------------------------------------------------------
module window_median_filter_4x4_core
  import wmf_pkg::*;
#(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [OUT_TDATA_W-1:0]            m_tdata,   // value, out_row, out_col, zero pad
  output logic                              m_tuser,   // is_median
  output logic                              m_tlast,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [APB_ADDR_W-1:0]             paddr,
  input  logic [APB_DATA_W-1:0]             pwdata,
  output logic [APB_DATA_W-1:0]             prdata,
  output logic                              pready
);

  localparam int ROW_W  = $clog2(MAX_ROWS);      // row counter
  localparam int COL_W  = $clog2(MAX_COLS);      // column counter, RAM address
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);  // effective row count
  localparam int CCNT_W = $clog2(MAX_COLS + 1);  // effective column count
  localparam int RX_W   = RCNT_W + 1;            // room for row + 2
  localparam int CX_W   = CCNT_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [REG_W-1:0] num_rows;
  logic [REG_W-1:0] num_cols;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= REG_W'(1024);
      num_cols <= REG_W'(1024);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NUM_ROWS: num_rows <= pwdata[REG_W-1:0];
        REG_NUM_COLS: num_cols <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_ROWS: prdata = APB_DATA_W'(num_rows);
      REG_NUM_COLS: prdata = APB_DATA_W'(num_cols);
      default:      prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, anything above the maximum as the maximum
  logic [RCNT_W-1:0] rows_eff;
  logic [CCNT_W-1:0] cols_eff;

  always_comb begin
    if (num_rows == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(num_rows) > 32'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(num_rows);
    end
    if (num_cols == '0) begin
      cols_eff = CCNT_W'(1);
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      cols_eff = CCNT_W'(MAX_COLS);
    end else begin
      cols_eff = CCNT_W'(num_cols);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together; the result stage stalls
  // everything until the last word it has to hand out is taken.
  // --------------------------------------------------------------------------
  logic               en;
  logic               accept;
  logic               v1;
  logic               v2;
  logic [NUM_RES-1:0] mask3;
  logic [NUM_RES-1:0] pick;
  logic               out_last;
  logic               m_hs;

  assign out_last = ((mask3 & ~pick) == '0);
  assign en       = (mask3 == '0) || (m_tready && out_last);
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign m_tvalid = (mask3 != '0);
  assign m_hs     = m_tvalid && m_tready;

  // --------------------------------------------------------------------------
  // Stage 0: position counters and emission flags of the incoming word
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt;
  logic [1:0]       slot;
  logic [RX_W-1:0]  rx;
  logic [RX_W-1:0]  rows_x;
  logic [CX_W-1:0]  cx;
  logic [CX_W-1:0]  cols_x;
  logic             row_end;
  logic             last_row;
  ctl_t             ctl0;

  assign rx     = RX_W'(row_cnt);
  assign rows_x = RX_W'(rows_eff);
  assign cx     = CX_W'(col_cnt);
  assign cols_x = CX_W'(cols_eff);

  assign row_end  = (cx + CX_W'(1) == cols_x);
  assign last_row = (rx + RX_W'(1) == rows_x);

  always_comb begin
    ctl0.emit[RES_DIAG]     = (row_cnt != '0) && (col_cnt != '0);
    ctl0.emit[RES_ROW_END]  = (row_cnt != '0) && row_end;
    ctl0.emit[RES_LAST_ROW] = last_row && (col_cnt != '0);
    ctl0.emit[RES_CORNER]   = last_row && row_end;
    // cell (r-1, c-1) is interior when r-1 in [2, rows-3] and c-1 in [2, cols-3]
    ctl0.interior = (rx >= RX_W'(3)) && (rx + RX_W'(2) <= rows_x) &&
                    (cx >= CX_W'(3)) && (cx + CX_W'(2) <= cols_x);
    ctl0.row = IDX_W'(row_cnt);
    ctl0.col = IDX_W'(col_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      slot    <= SLOT_0;
    end else if (cfg_wr) begin
      // any register write restarts the layer
      row_cnt <= '0;
      col_cnt <= '0;
      slot    <= SLOT_0;
    end else if (accept) begin
      if (row_end) begin
        col_cnt <= '0;
        if (last_row) begin
          row_cnt <= '0;
          slot    <= SLOT_0;
        end else begin
          row_cnt <= row_cnt + ROW_W'(1);
          slot    <= (slot == SLOT_2) ? SLOT_0 : slot + 2'd1;
        end
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // Line buffers: slot k holds rows with row mod 3 == k. Reading the slot
  // being written returns the old sample, three rows up.
  logic [SAMPLE_BITS-1:0] sample_in;
  logic [SAMPLE_BITS-1:0] ram_rd [3];

  assign sample_in = s_tdata[SAMPLE_BITS-1:0];

  for (genvar k = 0; k < 3; k++) begin : g_line
    wmf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_COLS)
    ) u_line (
      .clk   (clk),
      .we    (accept && (slot == 2'(k))),
      .waddr (col_cnt),
      .wdata (sample_in),
      .re    (en),
      .raddr (col_cnt),
      .rdata (ram_rd[k])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 1: shift the window and build the pairwise compare matrix
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [1:0]             s1_slot;
  ctl_t                   s1_ctl;
  logic [SAMPLE_BITS-1:0] up3;   // row r-3
  logic [SAMPLE_BITS-1:0] up2;   // row r-2
  logic [SAMPLE_BITS-1:0] up1;   // row r-1
  logic [SAMPLE_BITS-1:0] win      [WIN_SIZE];
  logic [SAMPLE_BITS-1:0] win_next [WIN_SIZE];
  logic [WIN_SIZE-1:0]    le_next  [WIN_SIZE];
  logic [WIN_SIZE-1:0]    le       [WIN_SIZE];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sample <= sample_in;
      s1_slot   <= slot;
      s1_ctl    <= ctl0;
    end
  end

  always_comb begin
    unique case (s1_slot)
      SLOT_0: begin
        up3 = ram_rd[0];
        up2 = ram_rd[1];
        up1 = ram_rd[2];
      end
      SLOT_1: begin
        up3 = ram_rd[1];
        up2 = ram_rd[2];
        up1 = ram_rd[0];
      end
      SLOT_2: begin
        up3 = ram_rd[2];
        up2 = ram_rd[0];
        up1 = ram_rd[1];
      end
      default: begin
        up3 = ram_rd[0];
        up2 = ram_rd[1];
        up1 = ram_rd[2];
      end
    endcase
  end

  // window index = 4*row + col, row 0 oldest, col 3 newest
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 3; b++) begin
        win_next[a*4 + b] = win[a*4 + b + 1];
      end
    end
    win_next[3]  = up3;
    win_next[7]  = up2;
    win_next[11] = up1;
    win_next[15] = s1_sample;
  end

  // le[a][b], a < b: element a sorts no later than element b (stable order)
  always_comb begin
    for (int a = 0; a < WIN_SIZE; a++) begin
      for (int b = 0; b < WIN_SIZE; b++) begin
        le_next[a][b] = (b > a) ? (win_next[a] <= win_next[b]) : 1'b0;
      end
    end
  end

  // The window register doubles as the stage 2 copy: it moves only with a
  // word entering stage 2.
  always_ff @(posedge clk) begin
    if (en && v1) begin
      win <= win_next;
    end
    if (en) begin
      le <= le_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: rank every element and pick the one of rank 8
  // --------------------------------------------------------------------------
  ctl_t                   s2_ctl;
  logic [WIN_SIZE-1:0]    ahead [WIN_SIZE];
  logic [SAMPLE_BITS-1:0] median;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_comb begin
    median = '0;
    for (int a = 0; a < WIN_SIZE; a++) begin
      for (int b = 0; b < WIN_SIZE; b++) begin
        if (b < a) begin
          ahead[a][b] = le[b][a];
        end else if (b > a) begin
          ahead[a][b] = !le[a][b];
        end else begin
          ahead[a][b] = 1'b0;
        end
      end
      if ($countones(ahead[a]) == MED_RANK) begin
        median = median | win[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: result words of one input word, handed out lowest slot first
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] s3_val [NUM_RES];
  logic                   s3_interior;
  logic [IDX_W-1:0]       s3_row;
  logic [IDX_W-1:0]       s3_col;
  logic [1:0]             sel;
  logic [IDX_W-1:0]       row_o;
  logic [IDX_W-1:0]       col_o;
  logic [VALUE_W-1:0]     value_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      mask3 <= '0;
    end else if (en) begin
      v1    <= accept;
      v2    <= v1;
      mask3 <= v2 ? s2_ctl.emit : '0;
    end else if (m_hs) begin
      // drop the word just taken, hold the rest
      mask3 <= mask3 & ~pick;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_val[RES_DIAG]     <= s2_ctl.interior ? median : win[10];
      s3_val[RES_ROW_END]  <= win[11];
      s3_val[RES_LAST_ROW] <= win[14];
      s3_val[RES_CORNER]   <= win[15];
      s3_interior          <= s2_ctl.interior;
      s3_row               <= s2_ctl.row;
      s3_col               <= s2_ctl.col;
    end
  end

  always_comb begin
    priority if (mask3[RES_DIAG]) begin
      sel = RES_DIAG;
    end else if (mask3[RES_ROW_END]) begin
      sel = RES_ROW_END;
    end else if (mask3[RES_LAST_ROW]) begin
      sel = RES_LAST_ROW;
    end else begin
      sel = RES_CORNER;
    end
  end

  always_comb begin
    pick    = '0;
    pick[sel] = 1'b1;
    value_o = VALUE_W'(s3_val[sel]);
    unique case (sel)
      RES_DIAG: begin
        row_o   = s3_row - IDX_W'(1);
        col_o   = s3_col - IDX_W'(1);
        m_tuser = s3_interior;
      end
      RES_ROW_END: begin
        row_o   = s3_row - IDX_W'(1);
        col_o   = s3_col;
        m_tuser = 1'b0;
      end
      RES_LAST_ROW: begin
        row_o   = s3_row;
        col_o   = s3_col - IDX_W'(1);
        m_tuser = 1'b0;
      end
      RES_CORNER: begin
        row_o   = s3_row;
        col_o   = s3_col;
        m_tuser = 1'b0;
      end
      default: begin
        row_o   = s3_row;
        col_o   = s3_col;
        m_tuser = 1'b0;
      end
    endcase
  end

  assign m_tdata = OUT_TDATA_W'({col_o, row_o, value_o});
  assign m_tlast = out_last;

endmodule

FILE: rtl/core/wmf_ram.sv
// ----------------------------------------------------------------------------
// wmf_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered, read-first.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for window_median_filter_4x4_core
// Streams raster-order grids of Q8.24 samples through the filter under random
// backpressure on both sides. A predictor built into the scoreboard mirrors
// the line buffers and the 4x4 window, and every result word is compared
// field by field with the oldest cell it predicts.
// ----------------------------------------------------------------------------
module testbench;
  import wmf_pkg::*;

  localparam int GRID_MAX   = 1024;    // MAX_ROWS and MAX_COLS of the instance
  localparam int WORD_GOAL  = 350;     // sample words over the whole run
  localparam int LIMIT      = 600000;  // cycles before the run is declared hung

  // One output cell as the bench sees it
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               is_median;
    logic               last;
  } cell_t;

  // Scoreboard: mirrors the filter state and holds the cells still due
  class cell_tracker;
    logic [VALUE_W-1:0] lines [3*GRID_MAX];
    logic [VALUE_W-1:0] win [WIN_SIZE];
    logic [REG_W-1:0]   rows_reg;
    logic [REG_W-1:0]   cols_reg;
    int unsigned        row_at;
    int unsigned        col_at;
    cell_t              cells_due [$];
    int unsigned        mismatches;
    int unsigned        cells_seen;
    int unsigned        medians_seen;

    function new();
      rows_reg = REG_W'(GRID_MAX);
      cols_reg = REG_W'(GRID_MAX);
      row_at = 0;
      col_at = 0;
      foreach (lines[k]) lines[k] = '0;
      foreach (win[k]) win[k] = '0;
      mismatches = 0;
      cells_seen = 0;
      medians_seen = 0;
    endfunction

    // Any register write restarts the layer; stored rows stay
    function void set_size(logic idx, logic [REG_W-1:0] v);
      if (idx == REG_NUM_ROWS) rows_reg = v;
      else cols_reg = v;
      row_at = 0;
      col_at = 0;
    endfunction

    function int unsigned clamp_size(logic [REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return 32'(v);
    endfunction

    function logic [VALUE_W-1:0] upper_median();
      logic [VALUE_W-1:0] s [WIN_SIZE];
      logic [VALUE_W-1:0] t;
      int b;
      s = win;
      for (int a = 1; a < WIN_SIZE; a++) begin
        t = s[a];
        b = a - 1;
        while (b >= 0 && s[b] > t) begin
          s[b+1] = s[b];
          b--;
        end
        s[b+1] = t;
      end
      return s[MED_RANK];
    endfunction

    function void add_cell(logic [VALUE_W-1:0] v, int unsigned r, int unsigned c, logic med);
      cell_t e;
      e.value = v;
      e.row = r[IDX_W-1:0];
      e.col = c[IDX_W-1:0];
      e.is_median = med;
      e.last = 1'b0;
      cells_due = {cells_due, e};
    endfunction

    // Advance the mirror by one accepted sample and queue the cells it completes
    function void take_sample(logic [VALUE_W-1:0] s);
      int unsigned rows, cols, r, c, slot, n0;
      logic row_end, last_row;
      rows = clamp_size(rows_reg);
      cols = clamp_size(cols_reg);
      r = row_at;
      c = col_at;
      if (r >= rows) r = rows - 1;
      if (c >= cols) c = cols - 1;
      slot = r % 3;
      for (int a = 0; a < 4; a++) begin
        win[a*4]   = win[a*4+1];
        win[a*4+1] = win[a*4+2];
        win[a*4+2] = win[a*4+3];
      end
      win[3]  = lines[slot*GRID_MAX + c];
      win[7]  = lines[((slot+1)%3)*GRID_MAX + c];
      win[11] = lines[((slot+2)%3)*GRID_MAX + c];
      win[15] = s;
      lines[slot*GRID_MAX + c] = s;
      row_end = (c + 1 == cols);
      last_row = (r + 1 == rows);
      n0 = cells_due.size();
      if (r >= 1 && c >= 1) begin
        if (r >= 3 && r + 2 <= rows && c >= 3 && c + 2 <= cols)
          add_cell(upper_median(), r - 1, c - 1, 1'b1);
        else
          add_cell(win[10], r - 1, c - 1, 1'b0);
      end
      if (r >= 1 && row_end) add_cell(win[11], r - 1, c, 1'b0);
      if (last_row && c >= 1) add_cell(win[14], r, c - 1, 1'b0);
      if (last_row && row_end) add_cell(win[15], r, c, 1'b0);
      if (cells_due.size() > n0) cells_due[cells_due.size()-1].last = 1'b1;
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
        if (r >= rows) r = 0;
      end
      row_at = r;
      col_at = c;
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_cell(cell_t got);
      cell_t want;
      if (cells_due.size() == 0) begin
        $error("result word with nothing expected: row %0d col %0d value %08h",
               got.row, got.col, got.value);
        mismatches++;
        return;
      end
      want = cells_due.pop_front();
      cells_seen++;
      if (want.is_median) medians_seen++;
      compare_field("value", want.value, got.value);
      compare_field("out_row", VALUE_W'(want.row), VALUE_W'(got.row));
      compare_field("out_col", VALUE_W'(want.col), VALUE_W'(got.col));
      compare_field("is_median", VALUE_W'(want.is_median), VALUE_W'(got.is_median));
      compare_field("last", VALUE_W'(want.last), VALUE_W'(got.last));
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [VALUE_W-1:0]     s_tdata = '0;     // [31:0] sample
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [31:0] value, [41:32] out_row,
                                            // [51:42] out_col, [55:52] zero pad
  logic                   m_tuser;          // is_median
  logic                   m_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  cell_tracker track;
  bit          tx_stalls = 1'b1;   // sender may insert idle bursts
  bit          rx_stalls = 1'b1;   // receiver may drop tready in bursts
  int unsigned rx_hold = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned grids_set = 0;

  window_median_filter_4x4_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Hang guard: count every cycle and give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: drop tready in bursts of random length when allowed
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(1, 16) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check every result word accepted at a rising edge
  always @(posedge clk) begin
    cell_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.value = m_tdata[VALUE_W-1:0];
      got.row = m_tdata[VALUE_W +: IDX_W];
      got.col = m_tdata[VALUE_W+IDX_W +: IDX_W];
      got.is_median = m_tuser;
      got.last = m_tlast;
      track.match_cell(got);
    end
  end

  // Offer one sample word, possibly after an idle burst, and hold it until taken
  task automatic send_word(input logic [VALUE_W-1:0] v);
    int gap;
    if (tx_stalls && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    track.take_sample(v);
    words_sent++;
  endtask

  // Stop sending and wait for every predicted cell; optionally let the
  // pipeline run dry, since the last words may cause no result at all
  task automatic settle(input bit quiet_after);
    @(negedge clk) s_tvalid <= 1'b0;
    while (track.cells_due.size() != 0) @(posedge clk);
    if (quiet_after) repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(APB_DATA_W-REG_W){1'b0}}, v};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    track.set_size(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Reprogram the grid only once the block has gone idle; order of writes varies
  task automatic set_grid(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] cols);
    settle(1'b1);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_NUM_ROWS, rows);
      write_reg(REG_NUM_COLS, cols);
    end else begin
      write_reg(REG_NUM_COLS, cols);
      write_reg(REG_NUM_ROWS, rows);
    end
    grids_set++;
  endtask

  // Sample content: full range, heavy ties, extremes, or a cluster at the top
  function automatic logic [VALUE_W-1:0] pick_sample(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 7);
      2: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return $urandom;
        endcase
      end
      default: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
    endcase
  endfunction

  // Push a run of random words; optionally hold off halfway until all is out
  task automatic run_words(input int count, input int mode, input bit pause_midway);
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) settle(1'b0);
      send_word(pick_sample(mode));
    end
  endtask

  initial begin : main
    int unsigned rows, cols, cells, count, goal;
    track = new();
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: zero sizes act as a single cell, so each word is its own layer
    set_grid(REG_W'(0), REG_W'(0));
    send_word('1);
    send_word('0);
    // Smallest grid with an interior cell; ties and both extremes in the window
    set_grid(REG_W'(5), REG_W'(5));
    for (int k = 0; k < 25; k++) begin
      case (k % 4)
        0: send_word('0);
        1: send_word('1);
        2: send_word(32'h8000_0000);
        default: send_word(VALUE_W'(k));
      endcase
    end

    // Stop the random part early enough that the last grid and the closing
    // stretch land the total near the word goal
    goal = WORD_GOAL - 120;

    // Oversized registers clamp to the maximum; feed only a short stretch each
    set_grid(REG_W'(0), REG_W'(2047));
    run_words(40, 0, 1'b0);
    set_grid(REG_W'(2047), REG_W'(0));
    run_words(30, 2, 1'b1);
    set_grid(REG_W'(1024), REG_W'(6));
    run_words(30, 1, 1'b0);
    set_grid(REG_W'(3), REG_W'(1024));
    run_words(20, 3, 1'b0);

    // Random grids: mostly whole layers big enough for medians, some tiny
    // grids, and some layers cut short by a restart
    while (words_sent < goal) begin
      if ($urandom_range(0, 3) != 0) begin
        rows = $urandom_range(5, 8);
        cols = $urandom_range(5, 9);
      end else begin
        rows = $urandom_range(0, 4);
        cols = $urandom_range(0, 6);
      end
      tx_stalls = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      set_grid(REG_W'(rows), REG_W'(cols));
      cells = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
      count = cells * $urandom_range(1, 2);
      if ($urandom_range(0, 2) == 0) count += $urandom_range(1, cells);
      run_words(count, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
    end

    // Closing stretch at full rate on both sides
    tx_stalls = 1'b0;
    rx_stalls = 1'b0;
    rx_hold = 0;
    set_grid(REG_W'(6), REG_W'(7));
    run_words(84, 0, 1'b0);
    settle(1'b1);

    $display("Run covered %0d samples over %0d grid settings", words_sent, grids_set);
    $display("Checked %0d cells, %0d of them interior medians",
             track.cells_seen, track.medians_seen);
    if (track.mismatches == 0 && track.cells_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
